// File: rtl/voice_slot_allocator_top_defines.svh
// Assertion macros for the voice slot allocator.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef VOICE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voice slot allocator.
// No dependencies; imported by the controller, datapath and top level.
package vsa_pkg;

  localparam int DONE_BITS = 8;  // width of the finished-voice mask
  localparam int INDEX_W   = 3;  // width of the granted index field
  localparam int TDATA_W   = 8;  // byte-padded stream data width

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;      // item accepted: latch mask result, reset scan
    logic scan_step;  // read next stamp and compare the previous one
    logic commit;     // write stamp, bump counter, load output register
  } cmd_t;

  typedef struct packed {
    logic free_hit;   // incoming mask names a finished voice
    logic scan_last;  // scan index is at the last voice
    logic out_free;   // output register empty or being taken this cycle
  } status_t;

endpackage

// File: rtl/vsa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the voice slot allocator.
// Depends on vsa_pkg; drives commands into vsa_dp and reads its status.
module vsa_ctrl import vsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = status.free_hit ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare happens in the datapath this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/vsa_dp.sv
`timescale 1ns / 1ps
// Datapath for the voice slot allocator: stamp memory, counter, scan, output.
// Depends on vsa_pkg; commanded by vsa_ctrl.
module vsa_dp import vsa_pkg::*; #(
  parameter int NUM_VOICES  = 8,
  parameter int STAMP_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DONE_BITS-1:0] done_mask,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [INDEX_W-1:0]   voice_index,
  output logic                 stolen
);

  localparam int IDX_W  = $clog2(NUM_VOICES);
  localparam int PW     = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int MASK_N = (NUM_VOICES < DONE_BITS) ? NUM_VOICES : DONE_BITS;

  logic [STAMP_WIDTH-1:0] stamp_mem [NUM_VOICES];
  logic [NUM_VOICES-1:0]  stamp_vld;
  logic [STAMP_WIDTH-1:0] cnt;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [STAMP_WIDTH-1:0] rd_data;
  logic                   rd_vld;
  logic                   cmp_en;
  logic [STAMP_WIDTH-1:0] best;
  logic [PW-1:0]          pick;
  logic                   pick_stolen;
  logic [PW-1:0]          enc;
  logic                   free_hit;
  logic [STAMP_WIDTH-1:0] rd_eff;

  // lowest-numbered finished voice
  always_comb begin
    enc = '0;
    for (int i = MASK_N - 1; i >= 0; i--) begin
      if (done_mask[i]) begin
        enc = PW'(i);
      end
    end
  end

  assign free_hit = |done_mask[MASK_N-1:0];
  // a stamp not written since the last clear reads as all ones
  assign rd_eff   = rd_vld ? rd_data : '1;

  assign status.free_hit  = free_hit;
  assign status.scan_last = (scan_idx == IDX_W'(NUM_VOICES - 1));
  assign status.out_free  = !out_valid || out_ready;

  // stamp memory: one registered read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_data <= stamp_mem[scan_idx];
    end
    if (cmd.commit) begin
      stamp_mem[pick[IDX_W-1:0]] <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_vld <= '0;
      cnt       <= '0;
      cmp_en    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_step;
      if (cmd.start && (cnt == '0)) begin
        stamp_vld <= '0;
      end else if (cmd.commit) begin
        stamp_vld[pick[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.commit) begin
        cnt <= cnt + STAMP_WIDTH'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan bookkeeping and running minimum
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_idx    <= '0;
      best        <= '1;
      pick        <= free_hit ? enc : '0;
      pick_stolen <= !free_hit;
    end else begin
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        rd_idx   <= scan_idx;
        rd_vld   <= stamp_vld[scan_idx];
      end
      if (cmp_en && (rd_eff < best)) begin
        best <= rd_eff;
        pick <= PW'(rd_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      voice_index <= pick[INDEX_W-1:0];
      stolen      <= pick_stolen;
    end
  end

endmodule

// File: rtl/voice_slot_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the voice slot allocator: controller plus datapath.
// Depends on vsa_pkg, vsa_ctrl, vsa_dp and voice_slot_allocator_top_defines.svh.
//
// Usage:
//   Input channel (s_*): one item per voice request; s_tdata is the mask of
//   voices that have finished playing. Output channel (m_*): one item per
//   request with the granted voice index and a flag set when a busy voice
//   was stolen.
//   Flow: a request that finds a finished voice goes from acceptance straight
//   to the commit step. Otherwise every stamp is read through the
//   single read port of the stamp memory, one per cycle, and the last
//   stamp is compared in a drain step before the commit. A new request is
//   taken in the cycle after the result is loaded, so only one request is
//   in flight at a time.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following result is held
//   in the commit step until the register frees up, and no input is taken.
//   Reset clears the counter, the stamp valid bits and the output valid flag;
//   stamps read as all ones until written, so no clearing pass is needed.
`include "voice_slot_allocator_top_defines.svh"
module voice_slot_allocator_top import vsa_pkg::*; #(
  parameter int NUM_VOICES  = 8,
  parameter int STAMP_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [7:0] done_mask
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // [2:0] voice_index, [3] stolen, rest zero
);

  cmd_t               cmd;
  status_t            status;
  logic [INDEX_W-1:0] voice_index;
  logic               stolen;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  vsa_dp #(
    .NUM_VOICES  (NUM_VOICES),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .done_mask   (s_tdata[DONE_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .voice_index (voice_index),
    .stolen      (stolen)
  );

  // pack result fields, lowest field in the lowest bits, pad to a byte
  assign m_tdata = {{(TDATA_W - INDEX_W - 1){1'b0}}, stolen, voice_index};

  // one request in flight: no accept right after an accept
  `VSA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
  // a result is only loaded when the output register can take it
  `VSA_ASSERT_NOW(a_commit_room, cmd.commit, !m_tvalid || m_tready, "result overwrote a pending item")
  // a result appears only after a commit
  `VSA_ASSERT_NOW(a_rise_from_commit, $rose(m_tvalid), $past(cmd.commit), "output valid without commit")

endmodule

// File: tb/voice_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for voice_slot_allocator_top: directed and random voice requests,
// with grants predicted from a local free-first / oldest-victim model. Depends on vsa_pkg.
module voice_slot_allocator_top_tb import vsa_pkg::*;;

  localparam int VOICES      = 8;
  localparam int STAMP_W     = 32;
  localparam int RAND_ITEMS  = 650;
  localparam int QUIET_TAIL  = 100;      // last items run with no random gaps or stalls on either side
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [DONE_BITS-1:0] mask;
    bit                   wait_drain;   // hold the item until every grant is back
  } request_t;

  typedef struct {
    logic [INDEX_W-1:0] voice;
    logic               stolen;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;    // [7:0] done_mask
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;         // [2:0] voice_index, [3] stolen

  request_t requests[$];
  grant_t   grants_due[$];

  logic [STAMP_W-1:0] voice_stamp [VOICES];
  logic [STAMP_W-1:0] grant_count;

  int  sent        = 0;
  int  total_items = 0;
  int  errors      = 0;
  int  cycles      = 0;
  bit  in_taken    = 1'b0;
  int  send_gap    = 0;
  int  recv_stall  = 0;

  voice_slot_allocator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Grant one voice: lowest finished voice first, else the smallest stamp
  // (lowest index on ties). A zero count wipes all stamps to all ones first.
  function automatic grant_t grant_voice(input logic [DONE_BITS-1:0] mask);
    grant_t             g;
    int                 pick;
    logic [STAMP_W-1:0] best;
    pick     = -1;
    g.stolen = 1'b0;
    if (grant_count == '0) begin
      for (int i = 0; i < VOICES; i++) voice_stamp[i] = '1;
    end
    for (int i = 0; i < VOICES && i < DONE_BITS; i++) begin
      if (mask[i]) begin
        pick = i;
        break;
      end
    end
    if (pick < 0) begin
      best     = '1;
      pick     = 0;
      g.stolen = 1'b1;
      for (int i = 0; i < VOICES; i++) begin
        if (voice_stamp[i] < best) begin
          best = voice_stamp[i];
          pick = i;
        end
      end
    end
    voice_stamp[pick] = grant_count;
    grant_count       = grant_count + 1'b1;
    g.voice           = pick[INDEX_W-1:0];
    return g;
  endfunction

  function automatic void queue_request(input logic [DONE_BITS-1:0] mask, input bit drain);
    request_t r;
    r.mask       = mask;
    r.wait_drain = drain;
    requests.push_back(r);
  endfunction

  // Sample both channels at the rising edge: check the grant first, then
  // predict the request taken at the same edge.
  always @(posedge clk) begin
    grant_t g;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst) begin
      in_taken    <= 1'b0;
      grant_count = '0;
      for (int i = 0; i < VOICES; i++) voice_stamp[i] = '1;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected grant: voice_index %0d stolen %0d", m_tdata[2:0], m_tdata[3]);
          errors++;
        end else begin
          g = grants_due.pop_front();
          if (m_tdata[2:0] !== g.voice) begin
            $error("voice_index: expected %0d, actual %0d", g.voice, m_tdata[2:0]);
            errors++;
          end
          if (m_tdata[3] !== g.stolen) begin
            $error("stolen: expected %0d, actual %0d", g.stolen, m_tdata[3]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        grants_due.push_back(grant_voice(s_tdata[DONE_BITS-1:0]));
        sent = sent + 1;
      end
      in_taken <= s_tvalid && s_tready;
    end
  end

  // Request driver: hold the item until taken, then idle in bursts, wait for
  // every grant where the item asks for a drain, or advance to the next pending request.
  always @(negedge clk) begin
    request_t r;
    logic     nxt_valid;
    bit       quiet;
    quiet     = total_items > 0 && sent >= total_items - QUIET_TAIL;
    nxt_valid = s_tvalid;
    if (!rst && (!s_tvalid || in_taken)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (requests.size() > 0) begin
        if (requests[0].wait_drain && grants_due.size() != 0) begin
          nxt_valid = 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(1, 6) - 1;
        end else begin
          r         = requests.pop_front();
          nxt_valid = 1'b1;
          s_tdata   <= r.mask;
        end
      end
    end
    s_tvalid <= nxt_valid;
  end

  // Grant receiver: stall in random bursts outside the quiet tail.
  always @(negedge clk) begin
    bit quiet;
    quiet = total_items > 0 && sent >= total_items - QUIET_TAIL;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      recv_stall = $urandom_range(1, 6) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int kind;
    logic [DONE_BITS-1:0] mask;

    // Directed: steal with every stamp at all ones, repeat steal on voice 0,
    // full and top-bit masks, each single voice, two near-full masks, then a
    // run of steals to walk the oldest-victim order.
    queue_request(8'h00, 1'b0);
    queue_request(8'h00, 1'b0);
    queue_request(8'hff, 1'b0);
    queue_request(8'h80, 1'b0);
    for (int i = 0; i < DONE_BITS; i++) queue_request(8'(1 << i), 1'b0);
    queue_request(8'hfe, 1'b0);
    queue_request(8'h7f, 1'b0);
    for (int i = 0; i < 9; i++) queue_request(8'h00, 1'b0);

    // Random: mostly steals and single finished voices, with periodic
    // drain points where the sender waits for every grant.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4)      mask = 8'h00;
      else if (kind < 7) mask = 8'(1 << $urandom_range(0, DONE_BITS - 1));
      else               mask = 8'($urandom_range(0, 255));
      queue_request(mask, n % 150 == 0);
    end
    total_items = requests.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(sent == total_items && grants_due.size() == 0)) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
